// ----- hw/rtl/aesctr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and the S-box for the AES-256 CTR keystream block.
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int unsigned MaxGroupsDef = 8;
  localparam int unsigned NumRounds    = 14;
  localparam int unsigned NumWords     = 60;

  // Configuration register indexes
  localparam logic [2:0] RegKey0  = 3'd0;
  localparam logic [2:0] RegKey1  = 3'd1;
  localparam logic [2:0] RegKey2  = 3'd2;
  localparam logic [2:0] RegKey3  = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_EMIT0,
    ST_EMIT1
  } ctr_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ----- hw/rtl/aesctr_keyexp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_keyexp
// Iterative AES-256 key expansion, one 32-bit schedule word per cycle, into
// four word banks read one round key (128 bits) at a time.
// ----------------------------------------------------------------------------
module aesctr_keyexp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] key_i,
  input  logic [3:0]   rd_row_i,
  output logic         busy_o,
  output logic [127:0] rk_o
);

  logic [5:0]  idx_q;
  logic        busy_q;
  logic [7:0]  rcon_q;
  logic [31:0] win_q [8];
  logic [31:0] bank_q [4][15];
  logic [127:0] rk_q;
  logic [31:0] t, new_word;

  always_comb begin
    t = win_q[7];
    if (idx_q[2:0] == 3'd0) begin
      t = {aesctr_pkg::SBOX[win_q[7][7:0]],
           aesctr_pkg::SBOX[win_q[7][31:24]],
           aesctr_pkg::SBOX[win_q[7][23:16]],
           aesctr_pkg::SBOX[win_q[7][15:8]] ^ rcon_q};
    end else if (idx_q[2:0] == 3'd4) begin
      t = {aesctr_pkg::SBOX[win_q[7][31:24]], aesctr_pkg::SBOX[win_q[7][23:16]],
           aesctr_pkg::SBOX[win_q[7][15:8]], aesctr_pkg::SBOX[win_q[7][7:0]]};
    end
    if (idx_q < 6'd8) begin
      new_word = key_i[32*idx_q[2:0] +: 32];
    end else begin
      new_word = win_q[0] ^ t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b1;
      rcon_q <= 8'h01;
    end else if (start_i) begin
      idx_q  <= '0;
      busy_q <= 1'b1;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      if (idx_q >= 6'd8 && idx_q[2:0] == 3'd0) begin
        rcon_q <= aesctr_pkg::xtime(rcon_q);
      end
      if (idx_q == 6'(aesctr_pkg::NumWords - 1)) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      for (int k = 0; k < 7; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[7] <= new_word;
      bank_q[idx_q[1:0]][idx_q[5:2]] <= new_word;
    end
    rk_q <= {bank_q[3][rd_row_i], bank_q[2][rd_row_i],
             bank_q[1][rd_row_i], bank_q[0][rd_row_i]};
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule

// ----- hw/rtl/aesctr_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_round
// One AES round: SubBytes, ShiftRows, MixColumns (skipped on the final
// round) and AddRoundKey. Byte k of the state sits in bits 8k+7:8k.
// ----------------------------------------------------------------------------
module aesctr_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rk_i,
  input  logic         final_i,
  output logic [127:0] state_o
);

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = aesctr_pkg::SBOX[state_i[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[4*c];
      a1  = t[4*c+1];
      a2  = t[4*c+2];
      a3  = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ all ^ aesctr_pkg::xtime(a0 ^ a1);
      m[4*c+1] = a1 ^ all ^ aesctr_pkg::xtime(a1 ^ a2);
      m[4*c+2] = a2 ^ all ^ aesctr_pkg::xtime(a2 ^ a3);
      m[4*c+3] = a3 ^ all ^ aesctr_pkg::xtime(a3 ^ a0);
    end
    for (int k = 0; k < 16; k++) begin
      state_o[8*k +: 8] = (final_i ? t[k] : m[k]) ^ rk_i[8*k +: 8];
    end
  end

endmodule

// ----- hw/rtl/aes256_ctr_keystream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_ctr_keystream
// AES-256 counter-mode keystream generator with an iterative round unit.
// ----------------------------------------------------------------------------
// Usage: write the key words (index 0..3) and the nonce (index 4) through the
// cfg port while idle. A key write re-expands the schedule, during
// which s_axis_tready_o stays low; key or nonce writes clear the block counter.
// A request on the s_axis channel carries group_count in tdata[3:0] and the
// restart flag in tuser. Each group gives four blocks, each block two 64-bit
// items on m_axis; tlast marks the final item of the request. A request of
// zero groups gives nothing (restart still clears the counter).
// Timing: one round per cycle through a single shared round unit. Each block
// passes ST_LOAD (initial AddRoundKey), the rounds in ST_ROUND, then ST_EMIT0
// and ST_EMIT1, one 64-bit item each. A new request is taken only in ST_IDLE,
// after the final item of the previous request. Reset runs the schedule
// expansion for the all-zero key before the first request is taken. A stalled
// receiver holds the output register and the sequencer waits; no item is ever dropped.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream #(
  parameter int unsigned MAX_GROUPS = aesctr_pkg::MaxGroupsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [3:0] group_count, [7:4] zero
  input  logic        s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] keystream_word
  output logic        m_axis_tlast_o
);

  localparam int unsigned BW = $clog2(MAX_GROUPS * 4 + 1);

  aesctr_pkg::ctr_state_e state_q, state_d;
  logic [63:0]  key_q [4];
  logic [63:0]  nonce_q;
  logic [63:0]  ctr_q, ctr_d;
  logic [BW-1:0] left_q, left_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] st_q, st_d;
  logic         ov_q, ov_d, ol_q, ol_d;
  logic [63:0]  od_q, od_d;
  logic         key_wr, nonce_wr, exp_busy, accept, out_free;
  logic [127:0] rk, blk, rnd_out;
  logic [3:0]   gsel;

  assign key_wr   = cfg_we_i && (cfg_idx_i <= aesctr_pkg::RegKey3);
  assign nonce_wr = cfg_we_i && (cfg_idx_i == aesctr_pkg::RegNonce);

  aesctr_keyexp u_keyexp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (key_wr),
    .key_i    ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .rd_row_i (rnd_d),
    .busy_o   (exp_busy),
    .rk_o     (rk)
  );

  aesctr_round u_round (
    .state_i (st_q),
    .rk_i    (rk),
    .final_i (rnd_q == 4'(aesctr_pkg::NumRounds)),
    .state_o (rnd_out)
  );

  // counter block: nonce bytes, then big-endian counter
  always_comb begin
    blk[63:0] = nonce_q;
    for (int i = 0; i < 8; i++) begin
      blk[64 + 8*i +: 8] = ctr_q[8*(7-i) +: 8];
    end
  end

  assign s_axis_tready_o = (state_q == aesctr_pkg::ST_IDLE) && !exp_busy && !cfg_we_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ov_q || m_axis_tready_i;
  assign gsel = (s_axis_tdata_i[3:0] > 4'(MAX_GROUPS)) ? 4'(MAX_GROUPS)
                                                      : s_axis_tdata_i[3:0];

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    left_d  = left_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    ov_d    = ov_q && !m_axis_tready_i;
    od_d    = od_q;
    ol_d    = ol_q;
    case (state_q)
      aesctr_pkg::ST_IDLE: begin
        rnd_d = '0;
        if (key_wr || nonce_wr) begin
          ctr_d = '0;
        end
        if (accept) begin
          if (s_axis_tuser_i) begin
            ctr_d = '0;
          end
          left_d = BW'(gsel) << 2;
          if (gsel != 4'd0) begin
            state_d = aesctr_pkg::ST_LOAD;
          end
        end
      end
      aesctr_pkg::ST_LOAD: begin
        st_d    = blk ^ rk;
        rnd_d   = 4'd1;
        state_d = aesctr_pkg::ST_ROUND;
      end
      aesctr_pkg::ST_ROUND: begin
        st_d = rnd_out;
        if (rnd_q == 4'(aesctr_pkg::NumRounds)) begin
          rnd_d   = '0;
          state_d = aesctr_pkg::ST_EMIT0;
        end else begin
          rnd_d = rnd_q + 4'd1;
        end
      end
      aesctr_pkg::ST_EMIT0: begin
        if (out_free) begin
          ov_d    = 1'b1;
          od_d    = st_q[63:0];
          ol_d    = 1'b0;
          state_d = aesctr_pkg::ST_EMIT1;
        end
      end
      aesctr_pkg::ST_EMIT1: begin
        if (out_free) begin
          ov_d   = 1'b1;
          od_d   = st_q[127:64];
          ol_d   = (left_q == BW'(1));
          ctr_d  = ctr_q + 64'd1;
          left_d = left_q - BW'(1);
          state_d = (left_q == BW'(1)) ? aesctr_pkg::ST_IDLE : aesctr_pkg::ST_LOAD;
        end
      end
      default: state_d = aesctr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesctr_pkg::ST_IDLE;
      ctr_q   <= '0;
      left_q  <= '0;
      rnd_q   <= '0;
      ov_q    <= 1'b0;
      nonce_q <= '0;
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      left_q  <= left_d;
      rnd_q   <= rnd_d;
      ov_q    <= ov_d;
      if (key_wr) begin
        key_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end
      if (nonce_wr) begin
        nonce_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    od_q <= od_d;
    ol_q <= ol_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tlast_o  = ol_q;

endmodule
